[sv/dibsu_pkg.sv]
// Shared types and constants for the DIB scanline pixel unpacker.
`default_nettype none

package dibsu_pkg;

    typedef logic [7:0] byte_t;

    // pixel_mode codes
    localparam logic [2:0] MODE_1BPP  = 3'd0;
    localparam logic [2:0] MODE_4BPP  = 3'd1;
    localparam logic [2:0] MODE_8BPP  = 3'd2;
    localparam logic [2:0] MODE_16BPP = 3'd3;
    localparam logic [2:0] MODE_24BPP = 3'd4;
    localparam logic [2:0] MODE_32BPP = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_PIXEL_MODE = 2'd0;
    localparam logic [1:0] CFG_LINE_WIDTH = 2'd1;
    localparam logic [1:0] CFG_ROW_STRIDE = 2'd2;

    localparam logic [2:0]  RESET_PIXEL_MODE = MODE_8BPP;
    localparam logic [12:0] RESET_LINE_WIDTH = 13'd1;
    localparam logic [14:0] RESET_ROW_STRIDE = 15'd4;

    localparam logic [14:0] STRIDE_CAP = 15'd16384;
    localparam logic [3:0]  MAX_RESULTS = 4'd8;

    typedef enum logic [1:0] {
        KIND_BITS,
        KIND_NIBBLE,
        KIND_PASS
    } kind_t;

    // one classified input byte, handed from front to back
    typedef struct packed {
        byte_t      data;
        kind_t      kind;
        logic [3:0] count;     // results to emit, 1..8
        logic       row_end;   // row_end on the final result
    } cmd_t;

endpackage

`default_nettype wire

[sv/dibsu_front.sv]
// Front end: configuration registers, row tracking and classification of each input byte.
`default_nettype none

module dibsu_front
    import dibsu_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire byte_t       in_byte,
    output logic             push,
    output cmd_t             push_cmd,
    input  wire logic        q_ready
);

    logic [2:0]  pixel_mode_reg, pixel_mode_next;
    logic [12:0] line_width_reg, line_width_next;
    logic [14:0] row_stride_reg, row_stride_next;
    logic [13:0] row_byte_pos_reg, row_byte_pos_next;
    logic [13:0] row_units_reg, row_units_next;

    logic [12:0] width_eff;
    logic [14:0] stride_eff;
    logic [2:0]  mode_eff;
    logic [14:0] pos_plus1;
    logic        end_of_row;
    logic [13:0] width14;
    logic        has_room;
    logic [13:0] remaining;
    logic [14:0] width15;
    logic [14:0] pass_lim;
    logic [3:0]  count;
    logic        cap_end;
    kind_t       kind;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = q_ready;
    assign accept    = in_valid && q_ready;

    always_comb begin
        if (line_width_reg == 13'd0) begin
            width_eff = 13'd1;
        end else if (17'(line_width_reg) > 17'(MAX_WIDTH)) begin
            width_eff = 13'(MAX_WIDTH);
        end else begin
            width_eff = line_width_reg;
        end

        if (row_stride_reg == 15'd0) begin
            stride_eff = 15'd1;
        end else if (row_stride_reg > STRIDE_CAP) begin
            stride_eff = STRIDE_CAP;
        end else begin
            stride_eff = row_stride_reg;
        end

        mode_eff = (pixel_mode_reg > MODE_32BPP) ? MODE_8BPP : pixel_mode_reg;
    end

    always_comb begin
        pos_plus1  = 15'(row_byte_pos_reg) + 15'd1;
        end_of_row = (pos_plus1 >= stride_eff);
        width14    = 14'(width_eff);
        width15    = 15'(width_eff);
        has_room   = (row_units_reg < width14);
        remaining  = width14 - row_units_reg;
        pass_lim   = width15;
        count      = 4'd0;
        cap_end    = 1'b0;
        kind       = KIND_PASS;

        unique case (mode_eff)
            MODE_1BPP: begin
                kind = KIND_BITS;
                if (has_room) begin
                    count = (remaining >= 14'(MAX_RESULTS)) ? MAX_RESULTS : remaining[3:0];
                end
                cap_end = (row_units_reg + 14'(count) == width14);
            end
            MODE_4BPP: begin
                kind = KIND_NIBBLE;
                if (has_room) begin
                    count = (remaining >= 14'd2) ? 4'd2 : 4'd1;
                end
                cap_end = (row_units_reg + 14'(count) == width14);
            end
            default: begin
                // 8/16/24/32 bpp: one byte through while inside width * bytes per pixel
                unique case (mode_eff)
                    MODE_16BPP: pass_lim = width15 << 1;
                    MODE_24BPP: pass_lim = (width15 << 1) + width15;
                    MODE_32BPP: pass_lim = width15 << 2;
                    default:    pass_lim = width15;
                endcase
                if (15'(row_byte_pos_reg) < pass_lim) begin
                    count = 4'd1;
                end
                cap_end = (pos_plus1 == pass_lim);
            end
        endcase
    end

    always_comb begin
        push_cmd.data    = in_byte;
        push_cmd.kind    = kind;
        push_cmd.count   = count;
        push_cmd.row_end = end_of_row || cap_end;
        push             = accept && (count != 4'd0);
    end

    always_comb begin
        pixel_mode_next   = pixel_mode_reg;
        line_width_next   = line_width_reg;
        row_stride_next   = row_stride_reg;
        row_byte_pos_next = row_byte_pos_reg;
        row_units_next    = row_units_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PIXEL_MODE: pixel_mode_next = cfg_data[2:0];
                CFG_LINE_WIDTH: line_width_next = cfg_data[12:0];
                CFG_ROW_STRIDE: row_stride_next = cfg_data;
                default: ;
            endcase
        end

        if (accept) begin
            if (end_of_row) begin
                row_byte_pos_next = 14'd0;
                row_units_next    = 14'd0;
            end else begin
                row_byte_pos_next = pos_plus1[13:0];
                if (kind != KIND_PASS) begin
                    row_units_next = row_units_reg + 14'(count);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_mode_reg   <= RESET_PIXEL_MODE;
            line_width_reg   <= RESET_LINE_WIDTH;
            row_stride_reg   <= RESET_ROW_STRIDE;
            row_byte_pos_reg <= 14'd0;
            row_units_reg    <= 14'd0;
        end else begin
            pixel_mode_reg   <= pixel_mode_next;
            line_width_reg   <= line_width_next;
            row_stride_reg   <= row_stride_next;
            row_byte_pos_reg <= row_byte_pos_next;
            row_units_reg    <= row_units_next;
        end
    end

    row_restart_a: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && end_of_row |=> (row_byte_pos_reg == 14'd0) && (row_units_reg == 14'd0))
        else $error("row counters not cleared at end of row");

endmodule

`default_nettype wire

[sv/dibsu_queue.sv]
// Short command queue between front and back.
`default_nettype none

module dibsu_queue
    import dibsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      push_ready,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_cmd
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    cmd_t            slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] fill_reg, fill_next;
    logic            do_push, do_pop;

    assign push_ready = (fill_reg != CntW'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        fill_next = fill_reg + CntW'(do_push) - CntW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    no_overflow_a: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CntW'(DEPTH))
        else $error("queue fill count beyond depth");

    empty_ptrs_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty but pointers differ");

endmodule

`default_nettype wire

[sv/dibsu_back.sv]
// Back end: expands one queued command into its result items, one per cycle while the output is not stalled.
`default_nettype none

module dibsu_back
    import dibsu_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output byte_t     out_pixel,
    output logic      out_row_end,
    output logic      out_last
);

    cmd_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_pixel_reg, out_pixel_next;
    logic       out_row_end_reg, out_row_end_next;
    logic       out_last_reg, out_last_next;

    logic  out_free, emit, final_res, done;
    byte_t pixel;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = cur_valid_reg && out_free;
    assign final_res = ({1'b0, idx_reg} + 4'd1 == cur_reg.count);
    assign done      = emit && final_res;
    assign q_pop     = q_valid && (!cur_valid_reg || done);

    always_comb begin
        unique case (cur_reg.kind)
            KIND_BITS:   pixel = {7'd0, cur_reg.data[3'd7 - idx_reg]};
            KIND_NIBBLE: pixel = idx_reg[0] ? {4'd0, cur_reg.data[3:0]}
                                            : {4'd0, cur_reg.data[7:4]};
            default:     pixel = cur_reg.data;
        endcase
    end

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (q_pop) begin
            cur_next       = q_cmd;
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end else if (done) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            idx_next = idx_reg + 3'd1;
        end

        out_valid_next   = out_valid_reg;
        out_pixel_next   = out_pixel_reg;
        out_row_end_next = out_row_end_reg;
        out_last_next    = out_last_reg;
        if (emit) begin
            out_valid_next   = 1'b1;
            out_pixel_next   = pixel;
            out_last_next    = final_res;
            out_row_end_next = final_res && cur_reg.row_end;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg         <= cur_next;
        out_pixel_reg   <= out_pixel_next;
        out_row_end_reg <= out_row_end_next;
        out_last_reg    <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pixel   = out_pixel_reg;
    assign out_row_end = out_row_end_reg;
    assign out_last    = out_last_reg;

    count_range_a: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_reg.count != 4'd0) && (cur_reg.count <= MAX_RESULTS)
                          && ({1'b0, idx_reg} < cur_reg.count))
        else $error("command count or index out of range");

    row_end_on_last_a: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_row_end_reg |-> out_last_reg)
        else $error("row end flagged on a non-final item");

endmodule

`default_nettype wire

[sv/dib_scanline_pixel_unpacker.sv]
// Path: an accepted byte goes through the command queue and the back end's command
// register to the output register on m_. Throughput: the back end emits one item per
// cycle while m_ is not stalled; a byte gives up to 8 items at 1 bpp, up to 2 at 4 bpp
// and 1 in the pass-through modes; padding bytes push no command and are accepted at
// one per cycle while the command queue has room. Reset (aresetn low, synchronous):
// 8 bpp, width 1, stride 4, row counters zero, queue and output register empty.
`default_nettype none

module dib_scanline_pixel_unpacker
    import dibsu_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] src_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] pixel_byte
    output logic             m_tuser,   // [0] row_end
    output logic             m_tlast
);

    logic push, push_ready, q_valid, q_pop;
    cmd_t push_cmd, q_cmd;

    dibsu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_ready   (push_ready)
    );

    dibsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd)
    );

    dibsu_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pixel   (m_tdata),
        .out_row_end (m_tuser),
        .out_last    (m_tlast)
    );

endmodule

`default_nettype wire
